FILE: src/ows_pkg.sv
// Shared types and constants for the ROM search step block.
package ows_pkg;

    localparam int ROM_BITS_DEF = 64;
    localparam int POS_W        = 7;
    localparam int DISC_W       = 8;
    localparam int ROM_CODE_W   = 64;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 72;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_PAIR  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_RUNNING     = 3'd0,
        ST_DONE        = 3'd1,
        ST_NO_DEVICE   = 3'd2,
        ST_DATA_ERROR  = 3'd3,
        ST_NOT_STARTED = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic              device_present;
        logic [DISC_W-1:0] last_discrepancy;
        logic              id_bit;
        logic              complement_bit;
    } t_in_beat;

    typedef struct packed {
        logic                  direction_bit;
        t_status               status;
        logic [POS_W-1:0]      next_discrepancy;
        logic [ROM_CODE_W-1:0] rom_code;
    } t_result;

endpackage

FILE: src/onewire_rom_search_step_top.sv
// Top level of the ROM search step block: input register, search core, result register.
// A beat accepted into the input register waits there until the result register is
// free or being emptied, then passes through the core into the result register.
// Throughput: one beat per cycle while the receiver keeps up; the input register and
// output register decouple the two sides, and one pass of core logic handles each beat.
// Reset (synchronous, active low) empties both registers, clears the ROM and sets
// the saved discrepancy to 255 with no pass active.
module onewire_rom_search_step_top
    import ows_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, lowest bit up: device_present[0], last_discrepancy[8:1], id_bit[9],
    // complement_bit[10], zero fill[15:11].
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: command[0] (0 starts a pass, 1 carries a bit pair).
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata, lowest bit up: direction_bit[0], next_discrepancy[7:1], rom_code[71:8].
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[2:0].
    output logic [2:0]            o_m_axis_tuser
);

    // Input register. It holds one beat until the core can hand its result on.
    logic     r_in_valid;
    t_in_beat r_in;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic    w_fire;
    logic    w_in_accept;
    t_result w_result;

    // The core advances whenever a beat is waiting and the result register is
    // free or being emptied in the same cycle.
    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in.cmd              <= t_cmd'(i_s_axis_tuser);
            r_in.device_present   <= i_s_axis_tdata[0];
            r_in.last_discrepancy <= i_s_axis_tdata[8:1];
            r_in.id_bit           <= i_s_axis_tdata[9];
            r_in.complement_bit   <= i_s_axis_tdata[10];
        end
    end

    ows_core #(
        .ROM_BITS (ROM_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_beat   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.rom_code, r_out.next_discrepancy, r_out.direction_bit};
    assign o_m_axis_tuser  = r_out.status;

endmodule

FILE: src/ows_core.sv
// Search state registers and the per-beat direction decision.
module ows_core
    import ows_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_beat i_beat,
    output t_result  o_result
);

    localparam int KW = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
    localparam logic [POS_W-1:0] RomBitsPos = POS_W'(ROM_BITS);

    logic [ROM_BITS-1:0] r_rom,    n_rom;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [DISC_W-1:0]   r_saved,  n_saved;
    logic [POS_W-1:0]    r_found,  n_found;
    logic                r_active, n_active;

    logic [POS_W-1:0] w_k_full;
    logic [KW-1:0]    w_k;
    logic             w_old;
    logic             w_dir;
    logic             w_take_one;
    t_status          w_status;

    assign w_k_full   = RomBitsPos - r_pos;
    assign w_k        = w_k_full[KW-1:0];
    assign w_old      = r_rom[w_k];
    assign w_take_one = (r_saved > {1'b0, r_pos})
                        || (w_old && (r_saved != {1'b0, r_pos}));

    always_comb begin
        n_rom    = r_rom;
        n_pos    = r_pos;
        n_saved  = r_saved;
        n_found  = r_found;
        n_active = r_active;
        w_dir    = 1'b0;
        w_status = ST_RUNNING;
        if (i_beat.cmd == CMD_START) begin
            n_found = '0;
            n_saved = i_beat.last_discrepancy;
            if (!i_beat.device_present) begin
                n_active = 1'b0;
                n_pos    = '0;
                w_status = ST_NO_DEVICE;
            end else begin
                n_active = 1'b1;
                n_pos    = RomBitsPos;
            end
        end else if (!r_active || (r_pos == '0) || (r_pos > RomBitsPos)) begin
            n_active = 1'b0;
            w_status = ST_NOT_STARTED;
        end else if (i_beat.id_bit && i_beat.complement_bit) begin
            n_active = 1'b0;
            n_pos    = '0;
            w_status = ST_DATA_ERROR;
        end else begin
            w_dir = i_beat.id_bit;
            if (!i_beat.id_bit && !i_beat.complement_bit && w_take_one) begin
                // Conflict on the bus: follow the one branch and remember where.
                w_dir   = 1'b1;
                n_found = r_pos;
            end
            n_rom[w_k] = w_dir;
            n_pos      = r_pos - POS_W'(1);
            if (n_pos == '0) begin
                n_active = 1'b0;
                w_status = ST_DONE;
            end
        end
    end

    always_comb begin
        o_result.direction_bit    = w_dir;
        o_result.status           = w_status;
        o_result.next_discrepancy = n_found;
        o_result.rom_code         = ROM_CODE_W'(n_rom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom    <= '0;
            r_pos    <= '0;
            r_saved  <= '1;
            r_found  <= '0;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_rom    <= n_rom;
            r_pos    <= n_pos;
            r_saved  <= n_saved;
            r_found  <= n_found;
            r_active <= n_active;
        end
    end

    a_active_has_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos != '0))
        else $error("active pass with no positions left");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= RomBitsPos)
        else $error("bit position beyond ROM length");

    a_found_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= RomBitsPos)
        else $error("discrepancy beyond ROM length");

    a_done_idles : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (w_status == ST_DONE)) |=> !r_active)
        else $error("pass still active after its last position");

endmodule

FILE: tb/onewire_rom_search_step_top_test.sv
// Self-checking testbench for the 1-Wire ROM search step block.
`timescale 1ns / 100ps

module onewire_rom_search_step_top_test;
    import ows_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 150;

    // Clock, reset and the stream signals to and from the block.
    logic                  i_clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    // Beats waiting to be offered, and the results predicted for accepted beats.
    t_in_beat pending_beats[$];
    t_result  expected_results[$];
    t_in_beat offered_beat;

    // Idle rates in percent for each side, changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // A long receiver hold-off is asked for by bumping holds_asked.
    int unsigned holds_asked;
    int unsigned holds_done;
    int unsigned hold_left;

    int unsigned error_count;
    int unsigned cycle_count;

    // Private copy of the search state, updated once per accepted beat.
    logic [ROM_CODE_W-1:0] rom_model;
    logic [POS_W-1:0]      pos_model;
    logic [DISC_W-1:0]     saved_disc_model;
    logic [POS_W-1:0]      found_disc_model;
    logic                  pass_on_model;

    onewire_rom_search_step_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Advances the search by one beat and returns what the block should answer.
    // Positions count down from ROM_BITS to 1; position p lands in ROM bit
    // ROM_BITS - p, so the first bit read is bit 0.
    function automatic t_result search_step(input t_in_beat b);
        t_result r;
        int      k;
        logic    dir;
        logic    old_bit;
        r.direction_bit = 1'b0;
        r.status        = ST_RUNNING;
        if (b.cmd == CMD_START) begin
            // A start keeps the ROM, since its old bits steer the choices at conflicts;
            // it restarts the pass only when a device is present.
            found_disc_model = '0;
            saved_disc_model = b.last_discrepancy;
            if (!b.device_present) begin
                pass_on_model = 1'b0;
                pos_model     = '0;
                r.status      = ST_NO_DEVICE;
            end else begin
                pass_on_model = 1'b1;
                pos_model     = POS_W'(ROM_BITS_DEF);
            end
        end else if (!pass_on_model || pos_model == 0 || pos_model > ROM_BITS_DEF) begin
            pass_on_model = 1'b0;
            r.status      = ST_NOT_STARTED;
        end else if (b.id_bit && b.complement_bit) begin
            // No device answered this position: the bit is not stored.
            pass_on_model = 1'b0;
            pos_model     = '0;
            r.status      = ST_DATA_ERROR;
        end else begin
            k   = ROM_BITS_DEF - int'(pos_model);
            dir = b.id_bit;
            if (!b.id_bit && !b.complement_bit) begin
                old_bit = rom_model[k];
                if (saved_disc_model > pos_model ||
                    (old_bit && saved_disc_model != pos_model)) begin
                    dir              = 1'b1;
                    found_disc_model = pos_model;
                end
            end
            rom_model[k]    = dir;
            r.direction_bit = dir;
            pos_model       = pos_model - POS_W'(1);
            if (pos_model == 0) begin
                pass_on_model = 1'b0;
                r.status      = ST_DONE;
            end
        end
        r.next_discrepancy = found_disc_model;
        r.rom_code         = rom_model;
        return r;
    endfunction

    // Driver: offers queued beats, and predicts each one at the edge where it
    // is accepted. A new beat replaces the old one in the same assignment, so
    // tvalid is never dropped and raised within one step.
    always @(posedge i_clk) begin : driver
        t_in_beat nxt;
        if (!rst_n) begin
            s_tvalid         <= 1'b0;
            s_tdata          <= '0;
            s_tuser          <= 1'b0;
            rom_model        = '0;
            pos_model        = '0;
            saved_disc_model = 8'd255;
            found_disc_model = '0;
            pass_on_model    = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(search_step(offered_beat));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt          = pending_beats.pop_front();
                    offered_beat = nxt;
                    s_tvalid     <= 1'b1;
                    // tdata: device_present, last_discrepancy, id_bit,
                    // complement_bit, then zero fill up to 16 bits.
                    s_tdata      <= {5'b0, nxt.complement_bit, nxt.id_bit,
                                     nxt.last_discrepancy, nxt.device_present};
                    s_tuser      <= nxt.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: drives tready with random stalls or a long hold-off, and checks
    // every accepted result beat against the oldest prediction. The error
    // count is bumped with blocking assignments, since one beat can miss on
    // several fields at once.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            holds_done <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no prediction waiting: tdata %h tuser %0d",
                           m_tdata, m_tuser);
                    error_count = error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.direction_bit) begin
                        $error("direction_bit: expected %0d, got %0d",
                               want.direction_bit, m_tdata[0]);
                        error_count = error_count + 1;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        error_count = error_count + 1;
                    end
                    if (m_tdata[7:1] !== want.next_discrepancy) begin
                        $error("next_discrepancy: expected %0d, got %0d",
                               want.next_discrepancy, m_tdata[7:1]);
                        error_count = error_count + 1;
                    end
                    if (m_tdata[71:8] !== want.rom_code) begin
                        $error("rom_code: expected %h, got %h", want.rom_code, m_tdata[71:8]);
                        error_count = error_count + 1;
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (holds_asked != holds_done) begin
                holds_done <= holds_asked;
                hold_left  <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: a plain cycle counter that ends a run that hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic push_beat(input logic cmd, input logic present, input logic [7:0] disc,
                             input logic id, input logic cmp);
        t_in_beat b;
        b.cmd              = t_cmd'(cmd);
        b.device_present   = present;
        b.last_discrepancy = disc;
        b.id_bit           = id;
        b.complement_bit   = cmp;
        pending_beats.push_back(b);
    endtask

    // Start beat with random filler in the bit-pair fields, which it ignores.
    task automatic push_start(input logic present, input logic [7:0] disc);
        push_beat(CMD_START, present, disc, 1'($urandom), 1'($urandom));
    endtask

    // Bit-pair beat with random filler in the start fields.
    task automatic push_pair(input logic id, input logic cmp);
        push_beat(CMD_PAIR, 1'($urandom), 8'($urandom), id, cmp);
    endtask

    // Waits at falling edges until every queued beat is accepted and answered.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Fills the queue with about the given number of beats. Most of it is
    // whole search passes with random bus answers; the rest is noise such as
    // stray pairs, absent devices and passes cut short by a restart.
    task automatic push_random_phase(input int unsigned n_beats);
        int unsigned start_size;
        int unsigned pairs;
        int unsigned sel;
        logic [7:0]  disc;
        start_size = pending_beats.size();
        while (pending_beats.size() - start_size < n_beats) begin
            if ($urandom_range(99) < 75) begin
                case ($urandom_range(3))
                    0: disc = 8'd255;
                    1: disc = 8'($urandom_range(0, ROM_BITS_DEF));
                    2: disc = 8'($urandom);
                    default: disc = 8'($urandom_range(ROM_BITS_DEF - 8, ROM_BITS_DEF));
                endcase
                push_start(1'b1, disc);
                // One pass in ten is cut short, so the next start lands mid-pass.
                pairs = ($urandom_range(9) == 0) ? $urandom_range(1, ROM_BITS_DEF - 1)
                                                 : ROM_BITS_DEF;
                repeat (pairs) begin
                    sel = $urandom_range(999);
                    if (sel < 3)
                        push_pair(1'b1, 1'b1);
                    else if (sel < 450)
                        push_pair(1'b0, 1'b0);
                    else begin
                        sel = $urandom_range(1);
                        push_pair(sel[0], ~sel[0]);
                    end
                end
            end else begin
                repeat ($urandom_range(4, 12))
                    push_beat(1'($urandom), 1'($urandom), 8'($urandom),
                              1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Stimulus sequencer. Reset is driven at rising edges like every other
    // input; after that the queue is touched only at falling edges, well away
    // from the edges where the driver and monitor act.
    initial begin : stimulus
        rst_n         = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 69;
        holds_asked   = 0;
        error_count   = 0;
        repeat (RESET_LEN) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: every command, each bus answer and the special cases.
        push_pair(1'b0, 1'b1);          // pair before any pass has started
        push_start(1'b0, 8'd255);       // no device answered the reset
        push_pair(1'b1, 1'b0);          // pair while idle after no device
        push_start(1'b1, 8'd0);         // start with the smallest discrepancy
        push_pair(1'b0, 1'b1);          // all devices read 0
        push_pair(1'b1, 1'b0);          // all devices read 1
        push_pair(1'b0, 1'b0);          // conflict, nothing left to revisit
        push_pair(1'b1, 1'b1);          // no device on the bus: data error
        push_pair(1'b0, 1'b0);          // pair after the data error
        push_start(1'b1, 8'd255);       // first pass of a search
        push_pair(1'b0, 1'b0);          // conflict takes 1 on a first pass
        push_pair(1'b0, 1'b0);
        push_start(1'b1, 8'd64);        // restart in the middle of a pass
        push_pair(1'b0, 1'b0);          // conflict right at the saved position
        push_pair(1'b0, 1'b0);          // conflict below it takes 1
        push_pair(1'b0, 1'b0);
        push_start(1'b1, 8'd63);
        push_pair(1'b0, 1'b0);          // above the saved position: takes 0
        push_pair(1'b0, 1'b0);          // at the saved position: takes 0
        push_pair(1'b0, 1'b0);
        push_start(1'b0, 8'd200);       // no device with a large discrepancy
        push_pair(1'b1, 1'b1);          // data error pattern while idle
        push_start(1'b1, 8'd1);
        push_pair(1'b1, 1'b0);
        wait_drained();

        // Phase one: the receiver stalls more often than the sender idles.
        push_random_phase(PHASE_BEATS);
        wait_drained();

        // Phase two: the other way round.
        send_idle_pct = 69;
        recv_idle_pct = 29;
        push_random_phase(PHASE_BEATS);
        wait_drained();

        // Phase three: no idling on either side, plus a long receiver hold-off
        // while the sender keeps offering, so the block backs up and stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_phase(PHASE_BEATS);
        holds_asked = holds_asked + 1;
        wait_drained();

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
